/* src/hcbd_pkg.sv */
// Shared types, widths and codes for the chunked body decoder.
// Used by every module of the block; depends on nothing.
package hcbd_pkg;

  localparam int LEN_W  = 48;  // content_length / max_body_size width
  localparam int TRL_W  = 16;  // max_trailer_line and line counter width
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int ERR_W  = 3;
  localparam int IDX_W  = 2;   // config register index width

  localparam int DEF_MAX_HEX_DIGITS = 16;
  localparam int DEF_COUNT_BITS     = 48;
  localparam int QUEUE_DEPTH        = 2;

  // body modes
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LENGTH  = 2'd2;

  // body status
  localparam logic [STAT_W-1:0] STAT_PARSING = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY_SIZE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_HEX     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_SIZE_LONG   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_MISSING_EOL = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TRAILER_LONG = 3'd6;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_BODY_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CONTENT_LEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_BODY    = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_TRAILER = 2'd3;

  localparam logic [LEN_W-1:0] MAX_BODY_RESET    = 48'd1048576;
  localparam logic [TRL_W-1:0] MAX_TRAILER_RESET = 16'd8192;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [MODE_W-1:0] body_mode;
    logic [LEN_W-1:0]  content_length;
    logic [LEN_W-1:0]  max_body_size;
    logic [TRL_W-1:0]  max_trailer_line;
  } cfg_t;

  // classified input item
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

endpackage

/* src/http_chunked_body_decoder.sv */
// Top level of the HTTP/1.1 request-body decoder: config registers, front end,
// item queue and parser back end. Depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_ready  | restart, in_byte
//   out     | out_valid/out_ready| payload_byte, payload_valid, body_status, error_code
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Throughput is one item per clock while the output is not stalled: the parser updates
// all of its counters for a byte at once, and the two-entry queue keeps the input open
// while a result waits. Each accepted item passes a queue slot, then the result register.
// Reset (rst, synchronous) restores the register defaults and clears parse state;
// there is no clearing pass. A stalled output fills the queue and then drops in_ready.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = DEF_MAX_HEX_DIGITS,
  parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              restart,
  input  logic [7:0]        in_byte,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        payload_byte,
  output logic              payload_valid,
  output logic [STAT_W-1:0] body_status,
  output logic [ERR_W-1:0]  error_code,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t front_item;
  logic  q_ready;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Config must only be written while idle; the block itself does not enforce it, so writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_mode        <= MODE_NONE;
      cfg.content_length   <= '0;
      cfg.max_body_size    <= MAX_BODY_RESET;
      cfg.max_trailer_line <= MAX_TRAILER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BODY_MODE:   cfg.body_mode        <= cfg_data[MODE_W-1:0];
        REG_CONTENT_LEN: cfg.content_length   <= cfg_data;
        REG_MAX_BODY:    cfg.max_body_size    <= cfg_data;
        REG_MAX_TRAILER: cfg.max_trailer_line <= cfg_data[TRL_W-1:0];
        default:         ;
      endcase
    end
  end

  // Front end: classify each byte as CR, LF or hex digit.
  hcbd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .in_byte  (in_byte),
    .q_ready  (q_ready),
    .push     (push),
    .item     (front_item)
  );

  // Decouples the front end from a stalled output.
  hcbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (front_item),
    .wr_ready (q_ready),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  // Back end: phase machine, chunk/length counters, sticky status, result register.
  hcbd_back #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .body_status   (body_status),
    .error_code    (error_code)
  );

endmodule

/* src/hcbd_front.sv */
// Front end: accepts raw bytes and classifies them (CR, LF, hex digit value).
// Depends on hcbd_pkg; feeds hcbd_queue.
module hcbd_front
  import hcbd_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       restart,
  input  logic [7:0] in_byte,
  input  logic       q_ready,
  output logic       push,
  output item_t      item
);

  assign in_ready = q_ready;
  assign push     = in_valid & q_ready;

  always_comb begin
    item.restart = restart;
    item.data    = in_byte;
    item.is_cr   = (in_byte == CHAR_CR);
    item.is_lf   = (in_byte == CHAR_LF);
    item.is_hex  = 1'b0;
    item.hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin         // '0'..'9'
      item.is_hex  = 1'b1;
      item.hex_val = in_byte[3:0];
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin  // 'a'..'f'
      item.is_hex  = 1'b1;
      item.hex_val = 4'(in_byte[3:0] + 4'd9);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin  // 'A'..'F'
      item.is_hex  = 1'b1;
      item.hex_val = 4'(in_byte[3:0] + 4'd9);
    end
  end

endmodule

/* src/hcbd_queue.sv */
// Short FIFO of classified items between the front end and the parser.
// Depends on hcbd_pkg for item_t.
module hcbd_queue
  import hcbd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  wr_ready,
  input  logic  pop,
  output logic  rd_valid,
  output item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   count <= CW'(count + 1'b1);
        2'b01:   count <= CW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> wr_ready) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

/* src/hcbd_back.sv */
// Back end: body parser state (phase, counters, sticky status) and output register.
// Depends on hcbd_pkg; pops classified items from hcbd_queue.
module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = DEF_MAX_HEX_DIGITS,
  parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        payload_byte,
  output logic              payload_valid,
  output logic [STAT_W-1:0] body_status,
  output logic [ERR_W-1:0]  error_code
);

  localparam int CHUNK_W = 4 * MAX_HEX_DIGITS;
  localparam int DIG_W   = $clog2(MAX_HEX_DIGITS + 1);
  localparam int CMP_W   = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int SUM_W   = ((CMP_W > CHUNK_W) ? CMP_W : CHUNK_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] PH_SIZE     = 2'd0;
  localparam logic [1:0] PH_DATA     = 2'd1;
  localparam logic [1:0] PH_DATA_END = 2'd2;
  localparam logic [1:0] PH_TRAILER  = 2'd3;

  // parse state
  logic [1:0]            phase;
  logic [CHUNK_W-1:0]    chunk;
  logic [DIG_W-1:0]      dig_cnt;
  logic [COUNT_BITS-1:0] raw_total;
  logic [TRL_W-1:0]      line_len;
  logic                  saw_cr;
  logic [STAT_W-1:0]     st_status;
  logic [ERR_W-1:0]      st_err;

  logic [1:0]            phase_next;
  logic [CHUNK_W-1:0]    chunk_next;
  logic [DIG_W-1:0]      dig_cnt_next;
  logic [COUNT_BITS-1:0] raw_total_next;
  logic [TRL_W-1:0]      line_len_next;
  logic                  saw_cr_next;
  logic [STAT_W-1:0]     st_status_next;
  logic [ERR_W-1:0]      st_err_next;
  logic                  pvalid_next;

  // state as seen by this item (restart clears it first)
  logic [1:0]            e_phase;
  logic [CHUNK_W-1:0]    e_chunk;
  logic [DIG_W-1:0]      e_dig;
  logic [COUNT_BITS-1:0] e_raw;
  logic [TRL_W-1:0]      e_ll;
  logic                  e_cr;
  logic [STAT_W-1:0]     e_status;
  logic [ERR_W-1:0]      e_err;

  logic                  raw_carry;
  logic [COUNT_BITS-1:0] raw_inc;
  logic                  raw_inc_over;
  logic [SUM_W-1:0]      size_sum;
  logic                  sum_over;
  logic [COUNT_BITS-1:0] sum_sat;
  logic [CHUNK_W-1:0]    chunk_dec;
  logic [TRL_W-1:0]      ll1;
  logic [TRL_W-1:0]      ll2;
  logic                  ll_full_a;
  logic                  ll_full_b;
  logic                  len_over;
  logic                  raw_lt_len;

  assign q_pop = q_valid & (~out_valid | out_ready);

  always_comb begin
    if (q_item.restart) begin
      e_phase  = PH_SIZE;
      e_chunk  = '0;
      e_dig    = '0;
      e_raw    = '0;
      e_ll     = '0;
      e_cr     = 1'b0;
      e_status = STAT_PARSING;
      e_err    = ERR_NONE;
    end else begin
      e_phase  = phase;
      e_chunk  = chunk;
      e_dig    = dig_cnt;
      e_raw    = raw_total;
      e_ll     = line_len;
      e_cr     = saw_cr;
      e_status = st_status;
      e_err    = st_err;
    end
  end

  // counters and compares shared by the phases
  assign raw_carry    = (e_raw != CNT_MAX);
  assign raw_inc      = COUNT_BITS'(e_raw + COUNT_BITS'(raw_carry));
  assign raw_inc_over = CMP_W'(raw_inc) > CMP_W'(cfg.max_body_size);
  // raw total after the closing LF plus the declared chunk size
  assign size_sum     = SUM_W'(e_raw) + SUM_W'(e_chunk) + SUM_W'(raw_carry);
  assign sum_over     = size_sum > SUM_W'(cfg.max_body_size);
  assign sum_sat      = (size_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : size_sum[COUNT_BITS-1:0];
  assign chunk_dec    = CHUNK_W'(e_chunk - 1'b1);
  assign ll1          = TRL_W'(e_ll + 1'b1);
  assign ll2          = TRL_W'(ll1 + 1'b1);
  assign ll_full_a    = e_ll >= cfg.max_trailer_line;
  assign ll_full_b    = ll1 >= cfg.max_trailer_line;
  assign len_over     = cfg.content_length > cfg.max_body_size;
  assign raw_lt_len   = CMP_W'(e_raw) < CMP_W'(cfg.content_length);

  always_comb begin
    phase_next     = e_phase;
    chunk_next     = e_chunk;
    dig_cnt_next   = e_dig;
    raw_total_next = e_raw;
    line_len_next  = e_ll;
    saw_cr_next    = e_cr;
    st_status_next = e_status;
    st_err_next    = e_err;
    pvalid_next    = 1'b0;

    if (e_status == STAT_PARSING) begin
      case (cfg.body_mode)
        MODE_NONE: begin
          st_status_next = STAT_DONE;
        end
        MODE_CHUNKED: begin
          if (e_phase == PH_DATA) begin
            pvalid_next = 1'b1;
            chunk_next  = chunk_dec;
            if (chunk_dec == '0) begin
              phase_next  = PH_DATA_END;
              saw_cr_next = 1'b0;
            end
          end else begin
            raw_total_next = raw_inc;
            if (raw_inc_over) begin
              st_status_next = STAT_ERROR;
              st_err_next    = ERR_TOO_LARGE;
            end else begin
              case (e_phase)
                PH_SIZE: begin
                  if (e_cr) begin
                    saw_cr_next = 1'b0;
                    if (!q_item.is_lf) begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_BAD_HEX;
                    end else if (e_dig == '0) begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_EMPTY_SIZE;
                    end else if (sum_over) begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_TOO_LARGE;
                    end else begin
                      raw_total_next = sum_sat;
                      dig_cnt_next   = '0;
                      if (e_chunk == '0) begin
                        phase_next    = PH_TRAILER;
                        line_len_next = '0;
                      end else begin
                        phase_next = PH_DATA;
                      end
                    end
                  end else if (q_item.is_cr) begin
                    saw_cr_next = 1'b1;
                  end else if (e_dig >= DIG_W'(MAX_HEX_DIGITS)) begin
                    st_status_next = STAT_ERROR;
                    st_err_next    = ERR_SIZE_LONG;
                  end else if (!q_item.is_hex) begin
                    st_status_next = STAT_ERROR;
                    st_err_next    = ERR_BAD_HEX;
                  end else begin
                    chunk_next   = (e_chunk << 4) | CHUNK_W'(q_item.hex_val);
                    dig_cnt_next = DIG_W'(e_dig + 1'b1);
                  end
                end
                PH_DATA_END: begin
                  if (!e_cr) begin
                    if (q_item.is_cr) begin
                      saw_cr_next = 1'b1;
                    end else begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_MISSING_EOL;
                    end
                  end else if (q_item.is_lf) begin
                    saw_cr_next  = 1'b0;
                    phase_next   = PH_SIZE;
                    chunk_next   = '0;
                    dig_cnt_next = '0;
                  end else begin
                    st_status_next = STAT_ERROR;
                    st_err_next    = ERR_MISSING_EOL;
                  end
                end
                PH_TRAILER: begin
                  if (e_cr && q_item.is_lf) begin
                    saw_cr_next = 1'b0;
                    if (e_ll == '0) begin
                      st_status_next = STAT_DONE;
                    end else begin
                      line_len_next = '0;
                    end
                  end else if (e_cr) begin
                    // lone CR counts as a line character, then this byte
                    saw_cr_next = 1'b0;
                    if (ll_full_a) begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_TRAILER_LONG;
                    end else if (q_item.is_cr) begin
                      saw_cr_next   = 1'b1;
                      line_len_next = ll1;
                    end else if (ll_full_b) begin
                      st_status_next = STAT_ERROR;
                      st_err_next    = ERR_TRAILER_LONG;
                    end else begin
                      line_len_next = ll2;
                    end
                  end else if (q_item.is_cr) begin
                    saw_cr_next = 1'b1;
                  end else if (ll_full_a) begin
                    st_status_next = STAT_ERROR;
                    st_err_next    = ERR_TRAILER_LONG;
                  end else begin
                    line_len_next = ll1;
                  end
                end
                default: begin
                  phase_next = PH_SIZE;
                end
              endcase
            end
          end
        end
        MODE_LENGTH: begin
          if (len_over) begin
            st_status_next = STAT_ERROR;
            st_err_next    = ERR_TOO_LARGE;
          end else if (raw_lt_len) begin
            pvalid_next    = 1'b1;
            raw_total_next = raw_inc;
            if (CMP_W'(raw_inc) == CMP_W'(cfg.content_length)) begin
              st_status_next = STAT_DONE;
            end
          end else begin
            st_status_next = STAT_DONE;
          end
        end
        default: begin
          st_status_next = STAT_ERROR;
          st_err_next    = ERR_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      chunk     <= '0;
      dig_cnt   <= '0;
      raw_total <= '0;
      line_len  <= '0;
      saw_cr    <= 1'b0;
      st_status <= STAT_PARSING;
      st_err    <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase     <= phase_next;
        chunk     <= chunk_next;
        dig_cnt   <= dig_cnt_next;
        raw_total <= raw_total_next;
        line_len  <= line_len_next;
        saw_cr    <= saw_cr_next;
        st_status <= st_status_next;
        st_err    <= st_err_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      payload_byte  <= pvalid_next ? q_item.data : 8'd0;
      payload_valid <= pvalid_next;
      body_status   <= st_status_next;
      error_code    <= st_err_next;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk != '0))
    else $error("data phase with no bytes left");
  a_digits_bound: assert property (@(posedge clk) disable iff (rst)
    dig_cnt <= DIG_W'(MAX_HEX_DIGITS))
    else $error("size digit count beyond limit");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (st_status == STAT_ERROR && !(q_pop && q_item.restart)) |=> (st_status == STAT_ERROR))
    else $error("error status dropped without restart");
  a_payload_not_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_valid) |-> (body_status != STAT_ERROR))
    else $error("payload byte reported with error status");
  a_code_needs_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> (body_status == STAT_ERROR))
    else $error("error code without error status");

endmodule
